@@ rtl/core/stepgen_pkg.sv @@
// Shared types, constants and the half-step coil table for the stepper step generator.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stepgen_pkg;

    // timing and rate limits
    localparam int TICKS_PER_SECOND = 1000000;
    localparam int MAX_RATE         = 5000;
    localparam int RESET_RATE       = 100;
    localparam int MIN_RATE         = 10;
    localparam int JOG_MAX          = 10;

    localparam int ELAPSED_W = 20;
    localparam int RATE_W    = 13;
    localparam int POS_W     = 32;
    localparam int CMD_W     = 4;
    localparam int JOG_W     = 4;
    localparam int PHASE_W   = 3;
    localparam int COIL_W    = 4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;
    localparam logic [ELAPSED_W-1:0] TICKS_WORD     = ELAPSED_W'(TICKS_PER_SECOND);
    localparam logic [ELAPSED_W-1:0] RESET_INTERVAL = ELAPSED_W'(TICKS_PER_SECOND / RESET_RATE);

    // speed tiers
    localparam logic [RATE_W-1:0] TIER_LO_LIMIT  = RATE_W'(100);
    localparam logic [RATE_W-1:0] TIER_MID_LIMIT = RATE_W'(1000);
    localparam logic [RATE_W-1:0] TIER_LO_STEP   = RATE_W'(10);
    localparam logic [RATE_W-1:0] TIER_MID_STEP  = RATE_W'(50);
    localparam logic [RATE_W-1:0] TIER_HI_STEP   = RATE_W'(250);

    // interval divider: one quotient bit per cycle
    localparam int DIV_STEPS = ELAPSED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_WIRING_MODE = PADDR_W'(0);

    // wiring modes
    localparam logic WIRING_STEP_DIR  = 1'b0;
    localparam logic WIRING_FOUR_WIRE = 1'b1;

    // command codes on s_cmd
    localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_JOG     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RUN     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ZERO    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_HOME    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FASTER  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SLOWER  = 4'd8;

    typedef enum logic [3:0] {
        OP_TICK,
        OP_JOG,
        OP_RUN,
        OP_REVERSE,
        OP_ENABLE,
        OP_ZERO,
        OP_HOME,
        OP_FASTER,
        OP_SLOWER,
        OP_NOP
    } op_code_t;

    typedef struct packed {
        op_code_t          code;
        logic              jog_fwd;
        logic [JOG_W-1:0]  jog_count;   // already clamped to JOG_MAX
    } op_t;

    typedef struct packed {
        logic we;
        logic wiring;
    } cfg_wr_t;

    typedef struct packed {
        logic                    step_strobe;
        logic                    dir_level;
        logic                    enable_n;
        logic [COIL_W-1:0]       coil_pattern;
        logic signed [POS_W-1:0] position_now;
        logic [RATE_W-1:0]       rate_now;
        logic                    running_now;
        logic                    homing_now;
        logic                    enabled_now;
        logic                    forward_now;
        logic                    home_reached;
        logic                    last_result;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_JOG  = 3'b010,
        ST_DIV  = 3'b100
    } back_state_t;

    function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        unique case (ph)
            3'd0:    c = 4'b0001;
            3'd1:    c = 4'b0011;
            3'd2:    c = 4'b0010;
            3'd3:    c = 4'b0110;
            3'd4:    c = 4'b0100;
            3'd5:    c = 4'b1100;
            3'd6:    c = 4'b1000;
            3'd7:    c = 4'b1001;
            default: c = 4'b0000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stepgen_front.sv @@
// Front end: decodes an incoming command word into a queue entry.
// Depends on stepgen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stepgen_front (
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [stepgen_pkg::CMD_W-1:0] s_cmd,
    input  wire logic                     s_jog_forward,
    input  wire logic [stepgen_pkg::JOG_W-1:0] s_jog_steps,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output stepgen_pkg::op_t              q_op
);
    import stepgen_pkg::*;

    assign q_valid = s_valid;
    assign s_ready = q_ready;

    always_comb begin
        q_op.jog_fwd   = s_jog_forward;
        q_op.jog_count = (s_jog_steps > JOG_W'(JOG_MAX)) ? JOG_W'(JOG_MAX) : s_jog_steps;
        unique case (s_cmd)
            CMD_TICK:    q_op.code = OP_TICK;
            CMD_JOG:     q_op.code = OP_JOG;
            CMD_RUN:     q_op.code = OP_RUN;
            CMD_REVERSE: q_op.code = OP_REVERSE;
            CMD_ENABLE:  q_op.code = OP_ENABLE;
            CMD_ZERO:    q_op.code = OP_ZERO;
            CMD_HOME:    q_op.code = OP_HOME;
            CMD_FASTER:  q_op.code = OP_FASTER;
            CMD_SLOWER:  q_op.code = OP_SLOWER;
            default:     q_op.code = OP_NOP;   // unused codes are ignored
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/stepgen_queue.sv @@
// Short command queue between front and back.
// Depends on stepgen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stepgen_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire stepgen_pkg::op_t wr_op,
    output logic                  rd_valid,
    input  wire logic             rd_pop,
    output stepgen_pkg::op_t      rd_op
);
    import stepgen_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = entry_reg[rd_ptr_reg];

    assign push = wr_valid && wr_ready;
    assign pop  = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/stepgen_div.sv @@
// Restoring divider: step interval = ticks per second / rate, one bit per cycle.
// Depends on stepgen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stepgen_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [stepgen_pkg::RATE_W-1:0]    divisor,
    output logic                                   done,
    output logic [stepgen_pkg::ELAPSED_W-1:0]      quotient
);
    import stepgen_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [ELAPSED_W-1:0] quo_reg, quo_next;     // dividend shifts out, quotient shifts in
    logic [RATE_W-1:0]    dvs_reg, dvs_next;
    logic [RATE_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[ELAPSED_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        priority if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = TICKS_WORD;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            quo_next = {quo_reg[ELAPSED_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/stepgen_back.sv @@
// Back end: motor state, step timing, jog sequencing and the result register.
// Depends on stepgen_pkg and stepgen_div.
`timescale 1ns / 1ps
`default_nettype none

module stepgen_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire stepgen_pkg::cfg_wr_t cfg,
    output logic                     wiring_mode,
    input  wire logic                q_valid,
    output logic                     q_pop,
    input  wire stepgen_pkg::op_t    q_op,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output stepgen_pkg::result_t     m_result
);
    import stepgen_pkg::*;

    back_state_t          state_reg, state_next;
    logic                 wiring_reg, wiring_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [COIL_W-1:0]    coil_reg, coil_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [ELAPSED_W-1:0] interval_reg, interval_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 run_reg, run_next;
    logic                 home_reg, home_next;
    logic                 enable_reg, enable_next;
    logic                 fwd_reg, fwd_next;
    logic                 dir_reg, dir_next;
    logic [JOG_W-1:0]     jog_left_reg, jog_left_next;
    logic                 jog_fwd_reg, jog_fwd_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              res_reg, res_next;

    logic                 can_emit, emit, last, home_hit, strobe;
    logic                 do_step, step_fwd, div_start, div_done;
    logic [ELAPSED_W-1:0] elapsed_inc, div_quo;
    logic [RATE_W:0]      rate_sum;
    logic [RATE_W-1:0]    rate_inc, rate_dec;

    assign can_emit = !m_valid_reg || m_ready;

    stepgen_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (rate_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        rate_inc = (rate_reg < TIER_LO_LIMIT)  ? TIER_LO_STEP :
                   (rate_reg < TIER_MID_LIMIT) ? TIER_MID_STEP : TIER_HI_STEP;
        rate_dec = (rate_reg <= TIER_LO_LIMIT)  ? TIER_LO_STEP :
                   (rate_reg <= TIER_MID_LIMIT) ? TIER_MID_STEP : TIER_HI_STEP;
        rate_sum = {1'b0, rate_reg} + {1'b0, rate_inc};
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        wiring_next   = wiring_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        coil_next     = coil_reg;
        rate_next     = rate_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        run_next      = run_reg;
        home_next     = home_reg;
        enable_next   = enable_reg;
        fwd_next      = fwd_reg;
        dir_next      = dir_reg;
        jog_left_next = jog_left_reg;
        jog_fwd_next  = jog_fwd_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        last          = 1'b1;
        home_hit      = 1'b0;
        do_step       = 1'b0;
        step_fwd      = 1'b0;
        strobe        = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && can_emit) begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (q_op.code)
                        OP_TICK: begin
                            if ((run_reg || home_reg) && elapsed_inc >= interval_reg) begin
                                elapsed_next = '0;
                                if (home_reg) begin
                                    if (pos_reg == '0) begin
                                        home_next = 1'b0;
                                        home_hit  = 1'b1;
                                    end else begin
                                        do_step  = 1'b1;
                                        step_fwd = pos_reg[POS_W-1];
                                    end
                                end else begin
                                    do_step  = 1'b1;
                                    step_fwd = fwd_reg;
                                end
                            end else begin
                                elapsed_next = elapsed_inc;
                            end
                        end
                        OP_JOG: begin
                            run_next  = 1'b0;
                            home_next = 1'b0;
                            if (q_op.jog_count != '0) begin
                                // the burst itself is emitted from ST_JOG
                                emit          = 1'b0;
                                jog_left_next = q_op.jog_count;
                                jog_fwd_next  = q_op.jog_fwd;
                                state_next    = ST_JOG;
                            end
                        end
                        OP_RUN: begin
                            run_next  = !run_reg;
                            home_next = 1'b0;
                        end
                        OP_REVERSE: fwd_next = !fwd_reg;
                        OP_ENABLE: begin
                            enable_next = !enable_reg;
                            if (enable_reg) begin
                                coil_next = '0;
                            end
                        end
                        OP_ZERO: pos_next = '0;
                        OP_HOME: begin
                            home_next = 1'b1;
                            run_next  = 1'b0;
                        end
                        OP_FASTER: begin
                            rate_next  = (rate_sum > (RATE_W + 1)'(MAX_RATE)) ?
                                         RATE_W'(MAX_RATE) : rate_sum[RATE_W-1:0];
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        OP_SLOWER: begin
                            rate_next  = ({1'b0, rate_reg} > ({1'b0, rate_dec} + (RATE_W + 1)'(MIN_RATE))) ?
                                         rate_reg - rate_dec : RATE_W'(MIN_RATE);
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_JOG: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    do_step       = 1'b1;
                    step_fwd      = jog_fwd_reg;
                    last          = (jog_left_reg == JOG_W'(1));
                    jog_left_next = jog_left_reg - 1'b1;
                    if (last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    interval_next = div_quo;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // one step; a disabled driver yields the result but nothing moves
        if (do_step && enable_reg) begin
            if (wiring_reg == WIRING_STEP_DIR) begin
                dir_next = step_fwd;
                strobe   = 1'b1;
            end else begin
                phase_next = step_fwd ? phase_reg + 1'b1 : phase_reg - 1'b1;
                coil_next  = half_step_coils(phase_next);
            end
            pos_next = step_fwd ? pos_reg + 1'b1 : pos_reg - 1'b1;
        end

        // mode change: only to be written while idle, by the user; the block does not enforce it
        if (cfg.we && cfg.wiring != wiring_reg) begin
            wiring_next = cfg.wiring;
            run_next    = 1'b0;
            home_next   = 1'b0;
            coil_next   = '0;
            dir_next    = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        res_next     = res_reg;
        if (emit) begin
            res_next.step_strobe  = strobe;
            res_next.dir_level    = (wiring_reg == WIRING_STEP_DIR) && dir_next;
            res_next.enable_n     = !enable_next;
            res_next.coil_pattern = (wiring_reg == WIRING_FOUR_WIRE) ? coil_next : '0;
            res_next.position_now = signed'(pos_next);
            res_next.rate_now     = rate_next;
            res_next.running_now  = run_next;
            res_next.homing_now   = home_next;
            res_next.enabled_now  = enable_next;
            res_next.forward_now  = fwd_next;
            res_next.home_reached = home_hit;
            res_next.last_result  = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wiring_reg   <= WIRING_STEP_DIR;
            pos_reg      <= '0;
            phase_reg    <= '0;
            coil_reg     <= '0;
            rate_reg     <= RATE_W'(RESET_RATE);
            interval_reg <= RESET_INTERVAL;
            elapsed_reg  <= '0;
            run_reg      <= 1'b0;
            home_reg     <= 1'b0;
            enable_reg   <= 1'b1;
            fwd_reg      <= 1'b1;
            dir_reg      <= 1'b0;
            jog_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wiring_reg   <= wiring_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            coil_reg     <= coil_next;
            rate_reg     <= rate_next;
            interval_reg <= interval_next;
            elapsed_reg  <= elapsed_next;
            run_reg      <= run_next;
            home_reg     <= home_next;
            enable_reg   <= enable_next;
            fwd_reg      <= fwd_next;
            dir_reg      <= dir_next;
            jog_left_reg <= jog_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        jog_fwd_reg <= jog_fwd_next;
        res_reg     <= res_next;
    end

    assign wiring_mode = wiring_reg;
    assign m_valid     = m_valid_reg;
    assign m_result    = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/stepper_motor_step_generator_unit.sv @@
// Stepper step generator top level: APB register, command front end, queue, back end.
// Depends on stepgen_pkg, stepgen_front, stepgen_queue, stepgen_back (and stepgen_div).
// Flow: an accepted word enters the queue; the back end then pops it and registers its result.
// Throughput: one word per cycle for tick and flag commands while the result sink keeps up;
//   a jog of k steps is decoded first, then emits k results on consecutive cycles unless stalled;
//   faster/slower stall the back end while the divider (one quotient bit per cycle) rebuilds the interval.
// Reset: aresetn is synchronous, active low; clears queue and output valid,
//   loads rate 100, interval 10000 ticks, enabled, forward, step/dir wiring.
`timescale 1ns / 1ps
`default_nettype none

module stepper_motor_step_generator_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // APB-style configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [stepgen_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [stepgen_pkg::PDATA_W-1:0]       pwdata,
    output logic      [stepgen_pkg::PDATA_W-1:0]       prdata,
    output logic                                       pready,
    // command words
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [stepgen_pkg::CMD_W-1:0]         s_cmd,
    input  wire logic                                  s_jog_forward,
    input  wire logic [stepgen_pkg::JOG_W-1:0]         s_jog_steps,
    // result words
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_step_strobe,
    output logic                                       m_dir_level,
    output logic                                       m_enable_n,
    output logic      [stepgen_pkg::COIL_W-1:0]        m_coil_pattern,
    output logic signed [stepgen_pkg::POS_W-1:0]       m_position_now,
    output logic      [stepgen_pkg::RATE_W-1:0]        m_rate_now,
    output logic                                       m_running_now,
    output logic                                       m_homing_now,
    output logic                                       m_enabled_now,
    output logic                                       m_forward_now,
    output logic                                       m_home_reached,
    output logic                                       m_last_result
);
    import stepgen_pkg::*;

    logic    q_in_valid, q_in_ready, q_out_valid, q_pop;
    op_t     q_in_op, q_out_op;
    cfg_wr_t cfg;
    logic    wiring_mode;
    result_t res;

    // Register file: a single wiring_mode bit at offset 0. No wait states.
    assign pready     = 1'b1;
    assign cfg.we     = psel && penable && pwrite && (paddr == ADDR_WIRING_MODE);
    assign cfg.wiring = pwdata[0];
    assign prdata     = (paddr == ADDR_WIRING_MODE) ? PDATA_W'(wiring_mode) : '0;

    // front: classify and clamp the command word
    stepgen_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_jog_forward (s_jog_forward),
        .s_jog_steps   (s_jog_steps),
        .q_valid       (q_in_valid),
        .q_ready       (q_in_ready),
        .q_op          (q_in_op)
    );

    // decoupling queue: front keeps taking words while the back end is busy, until the queue is full
    stepgen_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_op    (q_in_op),
        .rd_valid (q_out_valid),
        .rd_pop   (q_pop),
        .rd_op    (q_out_op)
    );

    // back: motor state, step timing, result register
    stepgen_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .wiring_mode (wiring_mode),
        .q_valid     (q_out_valid),
        .q_pop       (q_pop),
        .q_op        (q_out_op),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (res)
    );

    assign m_step_strobe  = res.step_strobe;
    assign m_dir_level    = res.dir_level;
    assign m_enable_n     = res.enable_n;
    assign m_coil_pattern = res.coil_pattern;
    assign m_position_now = res.position_now;
    assign m_rate_now     = res.rate_now;
    assign m_running_now  = res.running_now;
    assign m_homing_now   = res.homing_now;
    assign m_enabled_now  = res.enabled_now;
    assign m_forward_now  = res.forward_now;
    assign m_home_reached = res.home_reached;
    assign m_last_result  = res.last_result;

endmodule

`default_nettype wire

@@ test/stepgen_checker.sv @@
// Scoreboard for the stepper step generator: tracks the command and result channels and
// the configuration port, predicts every result word and compares it field by field.
// Depends on stepgen_pkg.
`timescale 1ns / 1ps

module stepgen_checker (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [stepgen_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [stepgen_pkg::PDATA_W-1:0]       pwdata,
    input  wire logic [stepgen_pkg::PDATA_W-1:0]       prdata,
    input  wire logic                                  pready,
    input  wire logic                                  s_valid,
    input  wire logic                                  s_ready,
    input  wire logic [stepgen_pkg::CMD_W-1:0]         s_cmd,
    input  wire logic                                  s_jog_forward,
    input  wire logic [stepgen_pkg::JOG_W-1:0]         s_jog_steps,
    input  wire logic                                  m_valid,
    input  wire logic                                  m_ready,
    input  wire logic                                  m_step_strobe,
    input  wire logic                                  m_dir_level,
    input  wire logic                                  m_enable_n,
    input  wire logic [stepgen_pkg::COIL_W-1:0]        m_coil_pattern,
    input  wire logic signed [stepgen_pkg::POS_W-1:0]  m_position_now,
    input  wire logic [stepgen_pkg::RATE_W-1:0]        m_rate_now,
    input  wire logic                                  m_running_now,
    input  wire logic                                  m_homing_now,
    input  wire logic                                  m_enabled_now,
    input  wire logic                                  m_forward_now,
    input  wire logic                                  m_home_reached,
    input  wire logic                                  m_last_result,
    output int                                         fail_count,
    output int                                         pending,
    output int                                         step_gap,
    output logic                                       drive_enabled
);
    import stepgen_pkg::*;

    // half-step coil sequence, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_SEQ = {4'b1001, 4'b1000, 4'b1100, 4'b0100,
                                             4'b0110, 4'b0010, 4'b0011, 4'b0001};

    logic                 wiring;
    logic [POS_W-1:0]     pos;
    logic [PHASE_W-1:0]   phase;
    logic [COIL_W-1:0]    coils;
    logic [RATE_W-1:0]    rate;
    logic [ELAPSED_W-1:0] ticks_needed;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 running;
    logic                 homing;
    logic                 enabled;
    logic                 forward;
    logic                 dir_pin;
    int                   mismatches = 0;
    result_t              motor_words_due[$];

    function automatic logic [ELAPSED_W-1:0] ticks_per_step(input logic [RATE_W-1:0] r);
        return ELAPSED_W'(TICKS_PER_SECOND / ((r == 0) ? 1 : int'(r)));
    endfunction

    // one step; disabled driver swallows it
    task automatic move_one(input logic fwd, output logic strobe);
        strobe = 1'b0;
        if (enabled) begin
            if (wiring == WIRING_STEP_DIR) begin
                dir_pin = fwd;
                strobe  = 1'b1;
            end else begin
                phase = fwd ? phase + 1'b1 : phase - 1'b1;
                coils = HALF_STEP_SEQ[phase*4 +: 4];
            end
            pos = fwd ? pos + 1 : pos - 1;
        end
    endtask

    function automatic result_t snapshot(input logic strobe, input logic home,
                                         input logic last);
        result_t w;
        w.step_strobe  = strobe;
        w.dir_level    = (wiring == WIRING_STEP_DIR) && dir_pin;
        w.enable_n     = !enabled;
        w.coil_pattern = (wiring == WIRING_FOUR_WIRE) ? coils : '0;
        w.position_now = pos;
        w.rate_now     = rate;
        w.running_now  = running;
        w.homing_now   = homing;
        w.enabled_now  = enabled;
        w.forward_now  = forward;
        w.home_reached = home;
        w.last_result  = last;
        return w;
    endfunction

    task automatic apply_motor_word(input logic [CMD_W-1:0] cmd, input logic jog_fwd,
                                    input logic [JOG_W-1:0] jog_n);
        logic              strobe;
        logic              home;
        logic [JOG_W-1:0]  n;
        logic [RATE_W-1:0] delta;
        int                i;
        strobe = 1'b0;
        home   = 1'b0;
        n      = (jog_n > JOG_MAX) ? JOG_W'(JOG_MAX) : jog_n;
        case (cmd)
            CMD_TICK: begin
                if (elapsed != ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
                if ((running || homing) && elapsed >= ticks_needed) begin
                    elapsed = '0;
                    if (homing && pos == '0) begin
                        homing = 1'b0;
                        home   = 1'b1;
                    end else if (homing) begin
                        move_one(pos[POS_W-1], strobe);
                    end else begin
                        move_one(forward, strobe);
                    end
                end
            end
            CMD_JOG: begin
                running = 1'b0;
                homing  = 1'b0;
                for (i = 0; i < n; i++) begin
                    move_one(jog_fwd, strobe);
                    motor_words_due.push_back(snapshot(strobe, 1'b0, i == n - 1));
                end
            end
            CMD_RUN: begin
                running = !running;
                homing  = 1'b0;
            end
            CMD_REVERSE: forward = !forward;
            CMD_ENABLE: begin
                enabled = !enabled;
                if (!enabled)
                    coils = '0;
            end
            CMD_ZERO: pos = '0;
            CMD_HOME: begin
                homing  = 1'b1;
                running = 1'b0;
            end
            CMD_FASTER: begin
                if (rate < TIER_LO_LIMIT)
                    rate = rate + TIER_LO_STEP;
                else if (rate < TIER_MID_LIMIT)
                    rate = rate + TIER_MID_STEP;
                else
                    rate = rate + TIER_HI_STEP;
                if (rate > MAX_RATE)
                    rate = RATE_W'(MAX_RATE);
                ticks_needed = ticks_per_step(rate);
            end
            CMD_SLOWER: begin
                delta = (rate <= TIER_LO_LIMIT)  ? TIER_LO_STEP :
                        (rate <= TIER_MID_LIMIT) ? TIER_MID_STEP : TIER_HI_STEP;
                rate  = (rate > delta + MIN_RATE) ? rate - delta : RATE_W'(MIN_RATE);
                ticks_needed = ticks_per_step(rate);
            end
            default: ;
        endcase
        // a jog of at least one step already queued its own words
        if (!(cmd == CMD_JOG && n != 0))
            motor_words_due.push_back(snapshot(strobe, home, 1'b1));
    endtask

    task automatic check_bits(input string label, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, label, want, got);
        end
    endtask

    task automatic compare_word(input result_t want);
        check_bits("step_strobe",  want.step_strobe,  m_step_strobe);
        check_bits("dir_level",    want.dir_level,    m_dir_level);
        check_bits("enable_n",     want.enable_n,     m_enable_n);
        check_bits("coil_pattern", want.coil_pattern, m_coil_pattern);
        check_bits("position_now", want.position_now, m_position_now);
        check_bits("rate_now",     want.rate_now,     m_rate_now);
        check_bits("running_now",  want.running_now,  m_running_now);
        check_bits("homing_now",   want.homing_now,   m_homing_now);
        check_bits("enabled_now",  want.enabled_now,  m_enabled_now);
        check_bits("forward_now",  want.forward_now,  m_forward_now);
        check_bits("home_reached", want.home_reached, m_home_reached);
        check_bits("last_result",  want.last_result,  m_last_result);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wiring       = WIRING_STEP_DIR;
            pos          = '0;
            phase        = '0;
            coils        = '0;
            rate         = RATE_W'(RESET_RATE);
            ticks_needed = ticks_per_step(rate);
            elapsed      = '0;
            running      = 1'b0;
            homing       = 1'b0;
            enabled      = 1'b1;
            forward      = 1'b1;
            dir_pin      = 1'b0;
            motor_words_due.delete();
        end else begin
            // results first: a word accepted on this edge cannot answer yet
            if (m_valid && m_ready) begin
                if (motor_words_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word expected none got position %0h",
                             $time, m_position_now);
                end else begin
                    compare_word(motor_words_due.pop_front());
                end
            end
            if (psel && penable && pready && paddr == ADDR_WIRING_MODE) begin
                if (pwrite) begin
                    if (pwdata[0] != wiring) begin
                        wiring  = pwdata[0];
                        running = 1'b0;
                        homing  = 1'b0;
                        coils   = '0;
                        dir_pin = 1'b0;
                    end
                end else begin
                    check_bits("prdata", {31'b0, wiring}, prdata);
                end
            end
            if (s_valid && s_ready)
                apply_motor_word(s_cmd, s_jog_forward, s_jog_steps);
        end
        fail_count    <= mismatches;
        pending       <= motor_words_due.size();
        step_gap      <= int'(ticks_needed);
        drive_enabled <= enabled;
    end

endmodule

@@ test/tb_stepper_motor_step_generator_unit.sv @@
// Testbench top for the stepper step generator: clock, reset, command and register
// stimulus, result sink with random stalls, and the verdict.
// Depends on stepgen_pkg, the step generator RTL and stepgen_checker.
`timescale 1ns / 1ps

module tb_stepper_motor_step_generator_unit;
    import stepgen_pkg::*;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    // run budget: input words in the random part, and a hard cycle cap
    localparam int COMMAND_WORDS = 330;
    localparam int CYCLE_LIMIT   = 400000;
    // results drained by the sink before each long stall
    localparam int STALL_AT_A    = 60;
    localparam int STALL_AT_B    = 200;
    localparam int STALL_CYCLES  = 150;
    // tick bursts stay short so a run fits the budget
    localparam int HOME_TICKS_MAX = 16;
    localparam int RUN_TICKS_MAX  = 16;
    // settle time after the last result: pipeline plus the interval divider
    localparam int SETTLE_CYCLES = 30;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]    pwdata  = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd         = '0;
    logic                  s_jog_forward = 1'b0;
    logic [JOG_W-1:0]      s_jog_steps   = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_step_strobe;
    logic                  m_dir_level;
    logic                  m_enable_n;
    logic [COIL_W-1:0]     m_coil_pattern;
    logic signed [POS_W-1:0] m_position_now;
    logic [RATE_W-1:0]     m_rate_now;
    logic                  m_running_now;
    logic                  m_homing_now;
    logic                  m_enabled_now;
    logic                  m_forward_now;
    logic                  m_home_reached;
    logic                  m_last_result;

    // from the scoreboard: verdict inputs plus hints for sizing tick bursts
    int                    fail_count;
    int                    pending;
    int                    step_gap;
    logic                  drive_enabled;

    int                    cycle_count   = 0;
    int                    commands_sent = 0;
    int                    results_taken = 0;
    bit                    send_idling   = 1'b1;
    bit                    take_idling   = 1'b1;

    stepper_motor_step_generator_unit DUT (.*);

    stepgen_checker scoreboard (.*);

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one command word. The gap before it is drawn per word; idling switches on
    // and off now and then so there are also back-to-back stretches. Returns on the
    // accepting edge with s_valid still high, so a zero gap keeps the stream dense.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic fwd,
                         input logic [JOG_W-1:0] steps);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_idling = !send_idling;
        gap = send_idling ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_jog_forward <= fwd;
        s_jog_steps   <= steps;
        commands_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // non-jog commands carry random jog fields, which the block must ignore
    task automatic offer_cmd(input logic [CMD_W-1:0] cmd);
        offer(cmd, 1'($urandom_range(0, 1)), JOG_W'($urandom_range(0, 15)));
    endtask

    task automatic tick_burst(input int n);
        repeat (n) offer_cmd(CMD_TICK);
    endtask

    // Register write plus read-back, only once the block has drained. The negedge
    // lets the scoreboard count settle after the last accepted word.
    task automatic set_wiring(input logic mode);
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIRING_MODE;
        pwdata  <= PDATA_W'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result sink: per-word random stall, with two long holds so the internal
    // queue fills and s_ready drops while commands keep coming.
    initial begin : result_sink
        int gap;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                take_idling = !take_idling;
            gap = take_idling ? $urandom_range(0, 6) : 0;
            if (results_taken == STALL_AT_A || results_taken == STALL_AT_B)
                gap = STALL_CYCLES;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin : stimulus
        int  pick;
        int  n;
        int  k;
        bit  floor_done;
        floor_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, step/dir wiring ----
        set_wiring(WIRING_STEP_DIR);            // write of the reset value: no effect
        offer(CMD_JOG, 1'b1, 4'd1);
        offer(CMD_JOG, 1'b0, 4'd10);            // crosses zero, position goes negative
        offer(CMD_JOG, 1'b1, 4'd15);            // clamped to ten steps
        offer(CMD_JOG, 1'b0, 4'd0);             // no step, still one word
        offer_cmd(CMD_TICK);
        offer_cmd(CMD_REVERSE);
        offer_cmd(CMD_ENABLE);                  // disable
        offer(CMD_JOG, 1'b1, 4'd3);             // words come out, nothing moves
        offer_cmd(CMD_ENABLE);
        offer_cmd(CMD_UNUSED_LO);
        offer_cmd(CMD_UNUSED_HI);
        offer_cmd(CMD_FASTER);
        offer_cmd(CMD_SLOWER);
        offer_cmd(CMD_SLOWER);
        offer_cmd(CMD_ZERO);
        offer_cmd(CMD_RUN);
        offer_cmd(CMD_TICK);
        offer_cmd(CMD_RUN);
        offer_cmd(CMD_HOME);
        offer_cmd(CMD_TICK);

        // ---- directed part, four-wire coils ----
        set_wiring(WIRING_FOUR_WIRE);
        offer(CMD_JOG, 1'b1, 4'd9);             // phase wraps forward
        offer(CMD_JOG, 1'b0, 4'd10);            // and backward
        offer_cmd(CMD_ENABLE);                  // coils drop to zero
        offer_cmd(CMD_ENABLE);                  // and stay there until a step
        offer(CMD_JOG, 1'b0, 4'd2);
        set_wiring(WIRING_FOUR_WIRE);

        // ---- random part ----
        commands_sent = 0;
        // drive the rate up against its ceiling
        repeat (36) offer_cmd(CMD_FASTER);
        while (commands_sent < COMMAND_WORDS) begin
            // once, halfway: drive the rate down to its floor
            if (!floor_done && commands_sent >= COMMAND_WORDS / 2) begin
                floor_done = 1'b1;
                repeat (46) offer_cmd(CMD_SLOWER);
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // speed walk in one direction
                n = $urandom_range(1, 8);
                k = $urandom_range(0, 9);
                repeat (n) offer_cmd((k < 6) ? CMD_FASTER : CMD_SLOWER);
            end else if (pick < 38) begin
                offer(CMD_JOG, 1'($urandom_range(0, 1)), JOG_W'($urandom_range(0, 15)));
            end else if (pick < 58) begin
                // continuous run, maybe reversed midway, maybe stopped again
                if (!drive_enabled)
                    offer_cmd(CMD_ENABLE);
                offer_cmd(CMD_RUN);
                n = (step_gap * 3 > RUN_TICKS_MAX) ? RUN_TICKS_MAX : step_gap * 3;
                tick_burst($urandom_range(0, n));
                if ($urandom_range(0, 1))
                    offer_cmd(CMD_REVERSE);
                tick_burst($urandom_range(0, n / 2));
                if ($urandom_range(0, 9) < 7)
                    offer_cmd(CMD_RUN);
            end else if (pick < 72) begin
                // homing from a few steps either side of zero; later words may cut it short
                if (!drive_enabled)
                    offer_cmd(CMD_ENABLE);
                offer_cmd(CMD_ZERO);
                k = $urandom_range(0, 5);
                offer(CMD_JOG, 1'($urandom_range(0, 1)), JOG_W'(k));
                offer_cmd(CMD_HOME);
                tick_burst($urandom_range(1, HOME_TICKS_MAX));
            end else if (pick < 88) begin
                case ($urandom_range(0, 4))
                    0:       offer_cmd(CMD_REVERSE);
                    1:       offer_cmd(CMD_ENABLE);
                    2:       offer_cmd(CMD_ZERO);
                    3:       offer_cmd(CMD_TICK);
                    default: offer_cmd(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
                endcase
            end else if (pick < 95) begin
                // noise: any code, any jog fields
                repeat ($urandom_range(1, 4))
                    offer(CMD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          JOG_W'($urandom_range(0, 15)));
            end else begin
                set_wiring(($urandom_range(0, 1) != 0) ? WIRING_FOUR_WIRE : WIRING_STEP_DIR);
            end
        end

        // drain and let any trailing work finish before the verdict
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
